>>> rtl/ntc_adc_to_temperature_interp_core_assert.svh
// ----------------------------------------------------------------------------
// NTC converter assertion macros
// Shared property forms for the checker of the NTC converter core.
// ----------------------------------------------------------------------------
`ifndef NTC_ADC_TO_TEMPERATURE_INTERP_CORE_ASSERT_SVH
`define NTC_ADC_TO_TEMPERATURE_INTERP_CORE_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define NTCAI_ASSERT_SAME(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("NTC converter check failed in the same cycle");

// Condition holds in the cycle after the trigger.
`define NTCAI_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("NTC converter check failed in the next cycle");

`endif

>>> rtl/ntcai_pkg.sv
// ----------------------------------------------------------------------------
// NTC converter package
// Widths, limits, the ADC code table and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ntcai_pkg;

  // Field and index widths.
  localparam int CODE_W      = 12;
  localparam int TEMP_W      = 15;
  localparam int IDX_W       = 8;
  localparam int S_DATA_W    = 16;
  localparam int M_DATA_W    = 16;
  localparam int TABLE_LEN   = 146;
  localparam int TABLE_ENTRIES_DEF = 146;

  // Divider: the rounded quotient always fits in fifteen bits.
  localparam int DIV_STEPS   = 15;
  localparam int CNT_W       = 4;

  // Output limits in hundredths of a degree.
  localparam logic signed [TEMP_W-1:0] TEMP_LOW  = -15'sd4000;
  localparam logic signed [TEMP_W-1:0] TEMP_HIGH = 15'sd10500;

  // The first table entry sits at -40 degrees.
  localparam logic [8:0] DEG_OFFSET = 9'd40;

  // Twice the hundredths per degree, used for half-away rounding.
  localparam logic [28:0] CENTI_X2 = 29'd200;

  // ADC code at each whole degree, strictly descending.
  localparam logic [CODE_W-1:0] ADC_CODES [0:TABLE_LEN-1] = '{
    12'd3980, 12'd3972, 12'd3964, 12'd3955, 12'd3946, 12'd3936, 12'd3926, 12'd3915,
    12'd3904, 12'd3892, 12'd3880, 12'd3866, 12'd3853, 12'd3838, 12'd3823, 12'd3807,
    12'd3791, 12'd3773, 12'd3755, 12'd3736, 12'd3716, 12'd3696, 12'd3675, 12'd3652,
    12'd3629, 12'd3605, 12'd3581, 12'd3555, 12'd3528, 12'd3501, 12'd3472, 12'd3443,
    12'd3413, 12'd3381, 12'd3349, 12'd3316, 12'd3282, 12'd3248, 12'd3212, 12'd3176,
    12'd3139, 12'd3101, 12'd3062, 12'd3022, 12'd2982, 12'd2941, 12'd2900, 12'd2858,
    12'd2815, 12'd2772, 12'd2728, 12'd2684, 12'd2639, 12'd2595, 12'd2549, 12'd2504,
    12'd2459, 12'd2413, 12'd2367, 12'd2321, 12'd2275, 12'd2229, 12'd2184, 12'd2138,
    12'd2093, 12'd2048, 12'd2003, 12'd1958, 12'd1914, 12'd1870, 12'd1826, 12'd1783,
    12'd1741, 12'd1699, 12'd1657, 12'd1616, 12'd1576, 12'd1536, 12'd1497, 12'd1459,
    12'd1421, 12'd1384, 12'd1347, 12'd1312, 12'd1277, 12'd1242, 12'd1209, 12'd1176,
    12'd1144, 12'd1112, 12'd1082, 12'd1052, 12'd1022, 12'd994,  12'd966,  12'd939,
    12'd912,  12'd886,  12'd861,  12'd837,  12'd813,  12'd790,  12'd767,  12'd745,
    12'd724,  12'd703,  12'd683,  12'd663,  12'd644,  12'd626,  12'd608,  12'd590,
    12'd573,  12'd557,  12'd541,  12'd525,  12'd510,  12'd496,  12'd482,  12'd468,
    12'd455,  12'd442,  12'd429,  12'd417,  12'd405,  12'd394,  12'd383,  12'd372,
    12'd362,  12'd352,  12'd342,  12'd333,  12'd323,  12'd314,  12'd306,  12'd297,
    12'd289,  12'd281,  12'd274,  12'd266,  12'd259,  12'd252,  12'd245,  12'd239,
    12'd233,  12'd226
  };

  // Table lookup; entries past the listed codes read as zero.
  function automatic logic [CODE_W-1:0] adc_code(input logic [IDX_W-1:0] idx);
    logic [CODE_W-1:0] code;
    code = '0;
    if (int'(idx) < TABLE_LEN) begin
      code = ADC_CODES[idx];
    end
    return code;
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic check;
    logic search;
    logic diff;
    logic mul;
    logic scale;
    logic div;
    logic fin;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clamp;
    logic search_done;
    logic div_last;
  } stat_t;

endpackage

>>> rtl/ntcai_ctrl.sv
// ----------------------------------------------------------------------------
// NTC converter controller
// Sequences check, search, interpolation and division for one sample.
// ----------------------------------------------------------------------------
module ntcai_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_valid,
  output logic            s_ready,
  output logic            m_valid,
  input  logic            m_ready,
  input  ntcai_pkg::stat_t stat,
  output ntcai_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_DIFF   = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_SCALE  = 3'd5;
  localparam logic [2:0] S_DIV    = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign s_ready  = (state == S_IDLE);
  assign out_free = !m_valid || m_ready;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = stat.clamp ? S_FIN : S_SEARCH;
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        if (stat.search_done) begin
          state_next = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (stat.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      m_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.fin) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/ntcai_dp.sv
// ----------------------------------------------------------------------------
// NTC converter datapath
// Table search, interpolation product and serial rounding division.
// ----------------------------------------------------------------------------
module ntcai_dp #(
  parameter int TABLE_ENTRIES = ntcai_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic [ntcai_pkg::CODE_W-1:0]        adc_sample,
  input  ntcai_pkg::cmd_t                    cmd,
  output ntcai_pkg::stat_t                   stat,
  output logic signed [ntcai_pkg::TEMP_W-1:0] temperature_centi
);

  localparam int IW = ntcai_pkg::IDX_W;
  localparam int CW = ntcai_pkg::CODE_W;
  localparam int TW = ntcai_pkg::TEMP_W;
  localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

  logic [CW-1:0]        x_r;
  logic [IW-1:0]        lo_r, hi_r;
  logic                 cold_r, hot_r;
  logic [CW-1:0]        d_r, e_r;
  logic signed [8:0]    thi_r;
  logic signed [21:0]   m_r;
  logic                 neg_r;
  logic [27:0]          rem_r, divs_r;
  logic [TW-1:0]        q_r;
  logic [ntcai_pkg::CNT_W-1:0] cnt_r;

  logic [IW:0]          sum;
  logic [IW-1:0]        mid;
  logic [CW-1:0]        code_mid, code_lo, code_hi;
  logic                 cold_now, hot_now;
  logic signed [21:0]   prod;
  logic signed [21:0]   m_abs;
  logic [28:0]          scaled;
  logic signed [15:0]   q_signed, res;
  logic signed [TW-1:0] res_clamped;

  // Search midpoint and table reads.
  assign sum      = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid      = sum[IW:1];
  assign code_mid = ntcai_pkg::adc_code(mid);
  assign code_lo  = ntcai_pkg::adc_code(lo_r);
  assign code_hi  = ntcai_pkg::adc_code(hi_r);

  // End-of-table clamp tests.
  assign cold_now = (x_r >= ntcai_pkg::adc_code('0));
  assign hot_now  = (x_r <= ntcai_pkg::adc_code(LAST));

  // Interpolation product: whole-degree temperature times code span.
  assign prod  = thi_r * $signed({1'b0, d_r});
  assign m_abs = m_r[21] ? -m_r : m_r;
  assign scaled = {8'd0, m_abs[20:0]} * ntcai_pkg::CENTI_X2;

  // Signed result with range clamp.
  assign q_signed = $signed({1'b0, q_r});
  assign res      = neg_r ? -q_signed : q_signed;
  always_comb begin
    if (cold_r) begin
      res_clamped = ntcai_pkg::TEMP_LOW;
    end else if (hot_r) begin
      res_clamped = ntcai_pkg::TEMP_HIGH;
    end else if (res < 16'(ntcai_pkg::TEMP_LOW)) begin
      res_clamped = ntcai_pkg::TEMP_LOW;
    end else if (res > 16'(ntcai_pkg::TEMP_HIGH)) begin
      res_clamped = ntcai_pkg::TEMP_HIGH;
    end else begin
      res_clamped = res[TW-1:0];
    end
  end

  // Status to the controller.
  assign stat.clamp       = cold_now || hot_now;
  assign stat.search_done = ({1'b0, hi_r} <= ({1'b0, lo_r} + (IW+1)'(1)));
  assign stat.div_last    = (cnt_r == '0);

  // Datapath registers, each step enabled by its command.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r <= adc_sample;
    end
    if (cmd.check) begin
      cold_r <= cold_now;
      hot_r  <= hot_now;
      lo_r   <= '0;
      hi_r   <= LAST;
    end
    if (cmd.search && !stat.search_done) begin
      if (code_mid < x_r) begin
        hi_r <= mid;
      end else begin
        lo_r <= mid;
      end
    end
    if (cmd.diff) begin
      d_r   <= code_lo - code_hi;
      e_r   <= x_r - code_hi;
      thi_r <= $signed({1'b0, hi_r}) - $signed(ntcai_pkg::DEG_OFFSET);
    end
    if (cmd.mul) begin
      m_r <= prod - $signed({10'd0, e_r});
    end
    if (cmd.scale) begin
      neg_r  <= m_r[21];
      rem_r  <= scaled[27:0] + {16'd0, d_r};
      divs_r <= {1'b0, d_r, 1'b0, 14'd0};
      q_r    <= '0;
      cnt_r  <= ntcai_pkg::CNT_W'(ntcai_pkg::DIV_STEPS - 1);
    end
    // One quotient bit per cycle, divisor shifted down each step.
    if (cmd.div) begin
      if (rem_r >= divs_r) begin
        rem_r <= rem_r - divs_r;
        q_r   <= {q_r[TW-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[TW-2:0], 1'b0};
      end
      divs_r <= {1'b0, divs_r[27:1]};
      cnt_r  <= cnt_r - 1'b1;
    end
    if (cmd.fin) begin
      temperature_centi <= res_clamped;
    end
  end

endmodule

>>> rtl/ntc_adc_to_temperature_interp_core.sv
// ----------------------------------------------------------------------------
// NTC ADC to temperature converter
// Converts a 12-bit thermistor divider sample to hundredths of a degree C.
// ----------------------------------------------------------------------------
// Channel   | Direction | Payload
// s_axis    | in        | tdata[11:0] adc_sample
// m_axis    | out       | tdata[14:0] temperature_centi (two's complement)
//
// A sample beyond either table end goes from the check straight to the final state.
// Any other sample passes the check, up to 8 binary search probes and a search
// state that sees the pair closed, three interpolation steps, the one-bit-per-cycle
// divider and the final state, after which the controller returns to idle.
// One sample is in work at a time; the next is taken while a result waits.
// Reset is synchronous and clears the controller and the output valid.
// A stalled output holds the finished sample in the final state.
// ----------------------------------------------------------------------------
module ntc_adc_to_temperature_interp_core #(
  parameter int TABLE_ENTRIES = ntcai_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ntcai_pkg::S_DATA_W-1:0]  s_axis_tdata,  // [11:0] adc_sample
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ntcai_pkg::M_DATA_W-1:0]  m_axis_tdata   // [14:0] temperature_centi
);

  ntcai_pkg::cmd_t  cmd;
  ntcai_pkg::stat_t stat;
  logic signed [ntcai_pkg::TEMP_W-1:0] temperature_centi;

  // Sequencing.
  ntcai_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // Arithmetic and table search.
  ntcai_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk               (clk),
    .adc_sample        (s_axis_tdata[ntcai_pkg::CODE_W-1:0]),
    .cmd               (cmd),
    .stat              (stat),
    .temperature_centi (temperature_centi)
  );

  // Pad the result to whole bytes.
  assign m_axis_tdata = {1'b0, temperature_centi};

endmodule

>>> rtl/ntcai_chk.sv
// ----------------------------------------------------------------------------
// NTC converter port checker
// Watches the converter's ports for range, pacing and output stability.
// ----------------------------------------------------------------------------
`include "ntc_adc_to_temperature_interp_core_assert.svh"

module ntcai_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [ntcai_pkg::S_DATA_W-1:0] s_axis_tdata,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ntcai_pkg::M_DATA_W-1:0] m_axis_tdata
);

  logic in_xfer;
  logic signed [ntcai_pkg::TEMP_W-1:0] temp;

  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign temp    = $signed(m_axis_tdata[ntcai_pkg::TEMP_W-1:0]);

  // Results always lie within the clamp range with a zero pad bit.
  `NTCAI_ASSERT_SAME(a_range, clk, rst, m_axis_tvalid, (m_axis_tdata[ntcai_pkg::M_DATA_W-1] == 1'b0) && (temp >= ntcai_pkg::TEMP_LOW) && (temp <= ntcai_pkg::TEMP_HIGH))
  // After a transfer in, the input side closes while the sample is worked on.
  `NTCAI_ASSERT_NEXT(a_one_item, clk, rst, in_xfer, !s_axis_tready)
  // An input transfer never completes a result in the next cycle.
  `NTCAI_ASSERT_NEXT(a_no_instant, clk, rst, in_xfer && !m_axis_tvalid, !m_axis_tvalid)
  // A stalled result stays valid and unchanged.
  `NTCAI_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind ntc_adc_to_temperature_interp_core ntcai_chk u_ntcai_chk (.*);

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTC converter core testbench
// Streams ADC samples into the converter and checks each temperature against
// a behavioral predictor of the table search and rounded interpolation.
// Directed samples cover both clamp ends, exact table codes, rounding halves
// and the zero crossing. Random samples follow, with gaps and output stalls.
// ----------------------------------------------------------------------------
module testbench;

  localparam int TABLE_SIZE     = ntcai_pkg::TABLE_ENTRIES_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int SW             = ntcai_pkg::S_DATA_W;
  localparam int MW             = ntcai_pkg::M_DATA_W;
  localparam int TW             = ntcai_pkg::TEMP_W;
  localparam int CW             = ntcai_pkg::CODE_W;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [SW-1:0] s_axis_tdata = '0;   // [11:0] adc_sample
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [MW-1:0] m_axis_tdata;        // [14:0] temperature_centi

  // Temperatures still owed by the converter, oldest first.
  logic signed [TW-1:0] pending_temps[$];
  bit                   failed = 1'b0;
  bit                   steady_flow = 1'b0;
  int                   stall_left = 0;
  int                   idle_cycles = 0;

  ntc_adc_to_temperature_interp_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk = ~clk;

  // Table code at an index; indexes past the listed codes read as zero.
  function automatic int table_code(input int idx);
    return (idx < ntcai_pkg::TABLE_LEN) ? int'(ntcai_pkg::ADC_CODES[idx]) : 0;
  endfunction

  // Expected temperature in hundredths of a degree for one ADC sample.
  function automatic logic signed [TW-1:0] predict_temperature(
    input logic [CW-1:0] sample
  );
    int x, last, lo, hi, mid, d, num, mag, quo, res;
    x    = int'(sample);
    last = (TABLE_SIZE - 1) & 255;
    lo   = 0;
    hi   = last;
    if (x >= table_code(0)) begin
      res = int'(ntcai_pkg::TEMP_LOW);
    end else if (x <= table_code(last)) begin
      res = int'(ntcai_pkg::TEMP_HIGH);
    end else begin
      // Narrow to the pair with code[lo] >= x > code[hi].
      while (hi > lo + 1) begin
        mid = ((lo + hi) >> 1) & 255;
        if (table_code(mid) < x) begin
          hi = mid;
        end else begin
          lo = mid;
        end
      end
      d = table_code(lo) - table_code(hi);
      if (d <= 0) begin
        // A flat step gives the temperature of the lower index.
        res = -4000 + lo * 100;
      end else begin
        num = (-4000 + hi * 100) * d - 100 * (x - table_code(hi));
        mag = (num < 0) ? -num : num;
        // Nearest integer, halves away from zero.
        quo = (2 * mag + d) / (2 * d);
        res = (num < 0) ? -quo : quo;
      end
    end
    if (res < int'(ntcai_pkg::TEMP_LOW)) res = int'(ntcai_pkg::TEMP_LOW);
    if (res > int'(ntcai_pkg::TEMP_HIGH)) res = int'(ntcai_pkg::TEMP_HIGH);
    return res[TW-1:0];
  endfunction

  // Idle length: mostly short, now and then long.
  function automatic int idle_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    if (pick < 93) return $urandom_range(4, 16);
    return $urandom_range(17, 60);
  endfunction

  // Offer one sample and wait for its transfer; called at a rising edge.
  task automatic send_sample(input logic [CW-1:0] sample);
    int gap;
    gap = (!steady_flow && $urandom_range(0, 99) < 40) ? idle_length() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(SW - CW){1'b0}}, sample};
    do @(posedge clk); while (!s_axis_tready);
    pending_temps.push_back(predict_temperature(sample));
  endtask

  // Clamp ends, exact codes, rounding halves and the zero crossing.
  task automatic test_directed();
    logic [CW-1:0] samples[$];
    samples = '{12'd0, 12'd4095, 12'd3980, 12'd3981, 12'd3979, 12'd226, 12'd227,
                12'd225, 12'd2048, 12'd2047, 12'd3972, 12'd233, 12'd3973, 12'd1577,
                12'd3139, 12'd3140, 12'd3138, 12'd3101, 12'hAAA, 12'h555, 12'h800,
                12'h7FF, 12'd1000, 12'd500};
    foreach (samples[i]) send_sample(samples[i]);
  endtask

  // Uniform samples over the whole converter range.
  task automatic test_random_samples(input int count);
    repeat (count) send_sample(CW'($urandom_range(0, 4095)));
  endtask

  // Samples on and around table codes, where the search bounds matter most.
  task automatic test_table_neighbors(input int count);
    int idx, code;
    repeat (count) begin
      idx  = $urandom_range(0, TABLE_SIZE - 1);
      code = table_code(idx) + $urandom_range(0, 4) - 2;
      send_sample(CW'(code));
    end
  endtask

  // Back-to-back samples; the output stays ready once any stall in progress ends.
  task automatic test_steady_stream(input int count);
    steady_flow = 1'b1;
    test_random_samples(count);
    steady_flow = 1'b0;
  endtask

  // Output ready: random stalls unless the stream is held steady.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (!steady_flow && $urandom_range(0, 99) < 20) begin
      m_axis_tready <= 1'b0;
      stall_left    <= idle_length() - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each output transfer with the oldest expected temperature.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_temps.size() == 0) begin
        $error("temperature_centi: expected none, actual %0d",
               $signed(m_axis_tdata[TW-1:0]));
        failed = 1'b1;
      end else begin
        if (m_axis_tdata[TW-1:0] !== pending_temps[0]) begin
          $error("temperature_centi: expected %0d, actual %0d", pending_temps[0],
                 $signed(m_axis_tdata[TW-1:0]));
          failed = 1'b1;
        end
        if (m_axis_tdata[MW-1:TW] !== '0) begin
          $error("tdata pad: expected 0, actual %0b", m_axis_tdata[MW-1:TW]);
          failed = 1'b1;
        end
        void'(pending_temps.pop_front());
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_samples(650);
    test_table_neighbors(450);
    test_steady_stream(300);
    @(posedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_temps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> ntc_adc_to_temperature_interp_core.f
+incdir+rtl
rtl/ntcai_pkg.sv
rtl/ntcai_ctrl.sv
rtl/ntcai_dp.sv
rtl/ntc_adc_to_temperature_interp_core.sv
rtl/ntcai_chk.sv
verif/testbench.sv
